// File: src/stl_pkg.sv
// Shared types, token codes and keyword tables for the source text lexer.
`timescale 1ns / 1ps

package stl_pkg;

    localparam int NUMBER_BITS_DEF   = 63;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int VALUE_W           = 63;
    localparam int QUEUE_DEPTH       = 4;
    localparam int KW_COUNT          = 9;
    localparam int KW_MAX_LEN        = 6;

    localparam logic [1:0] ITEM_LEXEME = 2'd0;
    localparam logic [1:0] ITEM_TOKEN  = 2'd1;
    localparam logic [1:0] ITEM_ERROR  = 2'd2;

    localparam logic [1:0] ERR_BAD_CHAR   = 2'd0;
    localparam logic [1:0] ERR_LONE_BANG  = 2'd1;
    localparam logic [1:0] ERR_OPEN_STRING = 2'd2;

    localparam logic [4:0] K_EOF      = 5'd0;
    localparam logic [4:0] K_NUMBER   = 5'd1;
    localparam logic [4:0] K_STRING   = 5'd2;
    localparam logic [4:0] K_IDENT    = 5'd3;
    localparam logic [4:0] K_KEYWORD0 = 5'd4;
    localparam logic [4:0] K_ASSIGN   = 5'd13;
    localparam logic [4:0] K_EQ       = 5'd14;
    localparam logic [4:0] K_PLUS     = 5'd15;
    localparam logic [4:0] K_MINUS    = 5'd16;
    localparam logic [4:0] K_STAR     = 5'd17;
    localparam logic [4:0] K_SLASH    = 5'd18;
    localparam logic [4:0] K_LPAREN   = 5'd19;
    localparam logic [4:0] K_RPAREN   = 5'd20;
    localparam logic [4:0] K_SEMI     = 5'd21;
    localparam logic [4:0] K_GT       = 5'd22;
    localparam logic [4:0] K_GE       = 5'd23;
    localparam logic [4:0] K_LT       = 5'd24;
    localparam logic [4:0] K_LE       = 5'd25;
    localparam logic [4:0] K_NE       = 5'd26;

    localparam logic [1:0] PEND_ASSIGN = 2'd0;
    localparam logic [1:0] PEND_GT     = 2'd1;
    localparam logic [1:0] PEND_LT     = 2'd2;
    localparam logic [1:0] PEND_BANG   = 2'd3;

    localparam logic [4:0] OP_SINGLE [4] = '{K_ASSIGN, K_GT, K_LT, K_EOF};
    localparam logic [4:0] OP_DOUBLE [4] = '{K_EQ, K_GE, K_LE, K_NE};

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "H", "E", "N", 8'h00, 8'h00},
        '{"L", "A", "B", "E", "L", 8'h00},
        '{"G", "O", "T", "O", 8'h00, 8'h00},
        '{"L", "E", "T", 8'h00, 8'h00, 8'h00},
        '{"A", "R", "R", "A", "Y", 8'h00},
        '{"S", "T", "R", "I", "N", "G"},
        '{"S", "E", "T", 8'h00, 8'h00, 8'h00},
        '{"P", "R", "I", "N", "T", 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd5, 3'd4, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5
    };

    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b0000001,
        MODE_IDENT    = 7'b0000010,
        MODE_NUMBER   = 7'b0000100,
        MODE_STRING   = 7'b0001000,
        MODE_ESCAPE   = 7'b0010000,
        MODE_OPERATOR = 7'b0100000,
        MODE_ERROR    = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [1:0]         item_type;
        logic [4:0]         token_kind;
        logic [7:0]         text_byte;
        logic [VALUE_W-1:0] number_value;
        logic [1:0]         error_code;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        item_t      item0;
        item_t      item1;
    } res_t;

    typedef struct packed {
        item_t item;
        logic  last;
    } entry_t;

    function automatic item_t mk_token(input logic [4:0] kind,
                                       input logic [VALUE_W-1:0] value);
        item_t it;
        it              = '0;
        it.item_type    = ITEM_TOKEN;
        it.token_kind   = kind;
        it.number_value = value;
        return it;
    endfunction

    function automatic item_t mk_lexeme(input logic [4:0] kind, input logic [7:0] ch);
        item_t it;
        it            = '0;
        it.item_type  = ITEM_LEXEME;
        it.token_kind = kind;
        it.text_byte  = ch;
        return it;
    endfunction

    function automatic item_t mk_error(input logic [1:0] code);
        item_t it;
        it            = '0;
        it.item_type  = ITEM_ERROR;
        it.error_code = code;
        return it;
    endfunction

endpackage

// File: src/stl_core.sv
// Lexer state and the per-byte step that produces up to two result items.
`timescale 1ns / 1ps

module stl_core #(
    parameter int NUMBER_BITS   = stl_pkg::NUMBER_BITS_DEF,
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    src_byte,
    input  logic          eoi,
    output stl_pkg::res_t res
);
    import stl_pkg::*;

    localparam int LEN_W = $clog2(KEYWORD_CHARS + 2);
    localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

    mode_t                  mode_reg, mode_next;
    logic [1:0]             pend_reg, pend_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   any_reg, any_next;
    logic                   semi_reg, semi_next;
    logic [7:0]             kw_chars_reg [KEYWORD_CHARS];

    logic                   kw_we;
    logic [LEN_W-1:0]       kw_idx;
    logic [7:0]             kw_data;
    logic [7:0]             upper;
    logic [4:0]             ident_kind;
    logic                   flush_has;
    logic [4:0]             flush_kind;
    logic                   go_idle;
    logic [1:0]             cnt;
    item_t                  slot [2];

    function automatic logic [NUMBER_BITS-1:0] num_add(input logic [NUMBER_BITS-1:0] a,
                                                       input logic [3:0] d);
        logic [NUMBER_BITS+3:0] w;
        w = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + (NUMBER_BITS+4)'(d);
        if (w > {4'b0000, NUM_MAX})
            return NUM_MAX;
        return w[NUMBER_BITS-1:0];
    endfunction

    assign upper = (src_byte >= "a" && src_byte <= "z") ? src_byte - 8'd32 : src_byte;

    always_comb
    begin
        logic hit;
        ident_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (len_reg == LEN_W'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if (j < int'(KW_LEN[k]) && kw_chars_reg[j] != KW_TEXT[k][j])
                    hit = 1'b0;
            end
            if (hit)
                ident_kind = K_KEYWORD0 + 5'(k);
        end
    end

    always_comb
    begin
        flush_has  = 1'b1;
        flush_kind = K_NUMBER;
        unique case (mode_reg)
            MODE_IDENT:    flush_kind = ident_kind;
            MODE_NUMBER:   flush_kind = K_NUMBER;
            MODE_OPERATOR: flush_kind = OP_SINGLE[pend_reg];
            default:       flush_has  = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        any_next  = any_reg;
        semi_next = semi_reg;
        kw_we     = 1'b0;
        kw_idx    = len_reg;
        kw_data   = upper;
        go_idle   = 1'b0;
        cnt       = 2'd0;
        slot[0]   = '0;
        slot[1]   = '0;

        if (step && eoi)
        begin
            if (mode_reg == MODE_ERROR)
            begin
                cnt = 2'd0;
            end
            else if (mode_reg == MODE_STRING || mode_reg == MODE_ESCAPE)
            begin
                slot[0] = mk_error(ERR_OPEN_STRING);
                cnt     = 2'd1;
            end
            else if (mode_reg == MODE_OPERATOR && pend_reg == PEND_BANG)
            begin
                slot[0] = mk_error(ERR_LONE_BANG);
                cnt     = 2'd1;
            end
            else
            begin
                if (flush_has)
                begin
                    slot[0] = mk_token(flush_kind, VALUE_W'(acc_reg)
                                       & {VALUE_W{flush_kind == K_NUMBER}});
                    cnt = 2'd1;
                end
                slot[cnt[0]] = mk_token(K_EOF, '0);
                cnt          = cnt + 2'd1;
            end
            mode_next = MODE_IDLE;
            pend_next = PEND_ASSIGN;
            len_next  = '0;
            acc_next  = '0;
            any_next  = 1'b0;
            semi_next = 1'b0;
        end
        else if (step)
        begin
            unique case (mode_reg)
                MODE_ERROR:
                begin
                    cnt = 2'd0;
                end
                MODE_STRING:
                begin
                    if (src_byte == "\"")
                    begin
                        mode_next = MODE_IDLE;
                        slot[0]   = mk_token(K_STRING, '0);
                        cnt       = 2'd1;
                        any_next  = 1'b1;
                        semi_next = 1'b0;
                    end
                    else if (src_byte == "\\")
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        slot[0] = mk_lexeme(K_STRING, src_byte);
                        cnt     = 2'd1;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_STRING;
                    slot[0]   = mk_lexeme(K_STRING, (src_byte == "n") ? 8'd10 :
                                                    (src_byte == "t") ? 8'd9 : src_byte);
                    cnt       = 2'd1;
                end
                MODE_OPERATOR:
                begin
                    if (src_byte == "=")
                    begin
                        mode_next = MODE_IDLE;
                        slot[0]   = mk_token(OP_DOUBLE[pend_reg], '0);
                        cnt       = 2'd1;
                        any_next  = 1'b1;
                        semi_next = 1'b0;
                    end
                    else if (pend_reg == PEND_BANG)
                    begin
                        mode_next = MODE_ERROR;
                        slot[0]   = mk_error(ERR_LONE_BANG);
                        cnt       = 2'd1;
                    end
                    else
                    begin
                        slot[0]   = mk_token(flush_kind, '0);
                        cnt       = 2'd1;
                        any_next  = 1'b1;
                        semi_next = 1'b0;
                        go_idle   = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if ((src_byte >= "A" && src_byte <= "Z") ||
                        (src_byte >= "a" && src_byte <= "z") ||
                        (src_byte >= "0" && src_byte <= "9") || src_byte == "_")
                    begin
                        kw_we   = (len_reg < LEN_W'(KEYWORD_CHARS));
                        if (len_reg < LEN_W'(KEYWORD_CHARS + 1))
                            len_next = len_reg + LEN_W'(1);
                        slot[0] = mk_lexeme(K_IDENT, src_byte);
                        cnt     = 2'd1;
                    end
                    else
                    begin
                        slot[0]   = mk_token(ident_kind, '0);
                        cnt       = 2'd1;
                        any_next  = 1'b1;
                        semi_next = 1'b0;
                        go_idle   = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (src_byte >= "0" && src_byte <= "9")
                    begin
                        acc_next = num_add(acc_reg, src_byte[3:0]);
                        slot[0]  = mk_lexeme(K_NUMBER, src_byte);
                        cnt      = 2'd1;
                    end
                    else
                    begin
                        slot[0]   = mk_token(K_NUMBER, VALUE_W'(acc_reg));
                        cnt       = 2'd1;
                        any_next  = 1'b1;
                        semi_next = 1'b0;
                        go_idle   = 1'b1;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            if (go_idle)
            begin
                mode_next = MODE_IDLE;
                case (src_byte) inside
                    8'h20, 8'h09, 8'h0D:
                    begin
                        cnt = cnt;
                    end
                    8'h0A:
                    begin
                        if (any_next && !semi_next)
                        begin
                            slot[cnt[0]] = mk_token(K_SEMI, '0);
                            cnt          = cnt + 2'd1;
                            semi_next    = 1'b1;
                        end
                    end
                    "\"":
                    begin
                        mode_next = MODE_STRING;
                    end
                    "=":
                    begin
                        pend_next = PEND_ASSIGN;
                        mode_next = MODE_OPERATOR;
                    end
                    ">":
                    begin
                        pend_next = PEND_GT;
                        mode_next = MODE_OPERATOR;
                    end
                    "<":
                    begin
                        pend_next = PEND_LT;
                        mode_next = MODE_OPERATOR;
                    end
                    "!":
                    begin
                        pend_next = PEND_BANG;
                        mode_next = MODE_OPERATOR;
                    end
                    "+", "-", "*", "/", "(", ")", ";":
                    begin
                        slot[cnt[0]] = mk_token(
                            (src_byte == "+") ? K_PLUS   :
                            (src_byte == "-") ? K_MINUS  :
                            (src_byte == "*") ? K_STAR   :
                            (src_byte == "/") ? K_SLASH  :
                            (src_byte == "(") ? K_LPAREN :
                            (src_byte == ")") ? K_RPAREN : K_SEMI, '0);
                        cnt       = cnt + 2'd1;
                        any_next  = 1'b1;
                        semi_next = (src_byte == ";");
                    end
                    [8'h30:8'h39]:
                    begin
                        mode_next    = MODE_NUMBER;
                        acc_next     = num_add('0, src_byte[3:0]);
                        slot[cnt[0]] = mk_lexeme(K_NUMBER, src_byte);
                        cnt          = cnt + 2'd1;
                    end
                    [8'h41:8'h5A], [8'h61:8'h7A]:
                    begin
                        mode_next    = MODE_IDENT;
                        kw_we        = 1'b1;
                        kw_idx       = '0;
                        len_next     = LEN_W'(1);
                        slot[cnt[0]] = mk_lexeme(K_IDENT, src_byte);
                        cnt          = cnt + 2'd1;
                    end
                    default:
                    begin
                        mode_next    = MODE_ERROR;
                        slot[cnt[0]] = mk_error(ERR_BAD_CHAR);
                        cnt          = cnt + 2'd1;
                    end
                endcase
            end
        end
    end

    assign res.count = cnt;
    assign res.item0 = slot[0];
    assign res.item1 = slot[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pend_reg <= PEND_ASSIGN;
            len_reg  <= '0;
            acc_reg  <= '0;
            any_reg  <= 1'b0;
            semi_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            any_reg  <= any_next;
            semi_reg <= semi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEYWORD_CHARS; i++)
        begin
            if (kw_we && kw_idx == LEN_W'(i))
                kw_chars_reg[i] <= kw_data;
        end
    end

    a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && eoi |=> mode_reg == MODE_IDLE && !any_reg && !semi_reg)
        else $error("end of input did not return the lexer to idle");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ERROR && step && !eoi |-> res.count == 2'd0)
        else $error("results produced while in sticky error");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ERROR && !(step && eoi) |=> mode_reg == MODE_ERROR)
        else $error("sticky error left before end of input");

    a_no_step_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !step |-> res.count == 2'd0)
        else $error("results produced without a step");

endmodule

// File: src/source_text_lexer.sv
// Top level of the source text lexer: input register, lexer core, result queue.
`timescale 1ns / 1ps

// Streaming lexer. Source bytes arrive on the s_axis channel, one per transfer;
// s_axis_tlast marks end of input (the data byte of that transfer is ignored),
// which flushes any pending token, emits end-of-file (or an error item for an
// open string or lone '!'; none in the error state) and starts a new stream.
// Results leave on the m_axis channel: tuser gives the item type (lexeme byte,
// token or error), tdata the token kind, text byte, number value and error
// code, and tlast marks the last result caused by one input transfer.
// An accepted byte is registered, then stepped through the lexer into a
// four-entry result queue, from which its results are presented.
// Throughput: one byte per cycle while results are taken every cycle; the
// output port moves one result per cycle, so bytes that cause two results
// (a pending token ended by a byte that yields its own result) cost an extra
// output transfer.
// The core steps only when the queue has room for two results, so a stalled
// receiver fills the queue and then holds s_axis_tready low; nothing is lost.
// Reset clears the lexer state and empties the queue.

module source_text_lexer #(
    parameter int NUMBER_BITS   = stl_pkg::NUMBER_BITS_DEF,
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [4:0] token_kind, [12:5] text_byte,
                                        // [75:13] number_value, [77:76] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] item_type
    output logic        m_axis_tlast
);
    import stl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eoi_reg;
    logic             step;
    res_t             res;
    entry_t           queue_reg [QUEUE_DEPTH];
    entry_t           head;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign step          = in_valid_reg && (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tlast;
        end
    end

    stl_core #(
        .NUMBER_BITS   (NUMBER_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .src_byte (in_byte_reg),
        .eoi      (in_eoi_reg),
        .res      (res)
    );

    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tuser  = head.item.item_type;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {2'b00, head.item.error_code, head.item.number_value,
                            head.item.text_byte, head.item.token_kind};

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(res.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(res.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.count != 2'd0)
        begin
            queue_reg[wr_ptr_reg].item <= res.item0;
            queue_reg[wr_ptr_reg].last <= (res.count == 2'd1);
        end
        if (res.count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)].item <= res.item1;
            queue_reg[wr_ptr_reg + PTR_W'(1)].last <= 1'b1;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_results_show: assert property (@(posedge clk) disable iff (!rst_n)
        res.count != 2'd0 |=> m_axis_tvalid)
        else $error("queued results not presented");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg)
                                  && $stable(in_eoi_reg))
        else $error("registered input lost while waiting for queue room");

endmodule
